### rtl/core/pec_pkg.sv
package pec_pkg;

    localparam int LbaW    = 32;
    localparam int SptW    = 8;
    localparam int HpcW    = 9;
    localparam int Q1W     = 18;
    localparam int Q2W     = 10;
    localparam int SmallW  = SptW + Q1W;
    localparam int LimitW  = SptW + HpcW + Q2W;
    localparam int InDataW  = 112;
    localparam int OutDataW = 128;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 9;

    localparam logic [CfgIdxW-1:0] CFG_SPT = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HPC = 2'd1;

    localparam logic [7:0] CLAMP_HEAD = 8'd254;
    localparam logic [5:0] CLAMP_SEC  = 6'h3F;
    localparam logic [9:0] CLAMP_CYL  = 10'd1023;

    typedef struct packed {
        logic              empty;
        logic [7:0]        flag;
        logic [7:0]        ptype;
        logic [LbaW-1:0]   count;
        logic [LbaW-1:0]   rel;
        logic              begin_big;
        logic              end_big;
        logic [SmallW-1:0] begin_lba;
        logic [SmallW-1:0] end_lba;
    } pec_item_t;

    typedef struct packed {
        logic              empty;
        logic [7:0]        flag;
        logic [7:0]        ptype;
        logic [LbaW-1:0]   count;
        logic [LbaW-1:0]   rel;
        logic              begin_big;
        logic              end_big;
    } pec_side_t;

endpackage

### rtl/core/pec_front.sv
module pec_front (
    input  logic [pec_pkg::InDataW-1:0] in_data,
    input  logic [pec_pkg::SptW-1:0]    spt,
    input  logic [pec_pkg::HpcW-1:0]    hpc,
    output pec_pkg::pec_item_t          item
);
    import pec_pkg::*;

    logic [LbaW-1:0]   start_lba;
    logic [LbaW-1:0]   sector_count;
    logic [7:0]        part_type;
    logic [7:0]        boot_flag;
    logic [LbaW-1:0]   base_lba;
    logic [LbaW:0]     end_lba;
    logic [SptW+HpcW-1:0] track_prod;
    logic [LimitW-1:0] limit;

    assign start_lba    = in_data[31:0];
    assign sector_count = in_data[63:32];
    assign part_type    = in_data[71:64];
    assign boot_flag    = in_data[79:72];
    assign base_lba     = in_data[111:80];

    assign end_lba    = {1'b0, start_lba} + {1'b0, sector_count} - {{LbaW{1'b0}}, 1'b1};
    assign track_prod = {{HpcW{1'b0}}, spt} * {{SptW{1'b0}}, hpc};
    assign limit      = {track_prod, {Q2W{1'b0}}};

    always_comb begin
        item.empty     = (sector_count == '0) || (part_type == 8'd0);
        item.flag      = boot_flag;
        item.ptype     = part_type;
        item.count     = sector_count;
        item.rel       = start_lba - base_lba;
        item.begin_big = {1'b0, start_lba} >= {{(LbaW + 1 - LimitW){1'b0}}, limit};
        item.end_big   = end_lba >= {{(LbaW + 1 - LimitW){1'b0}}, limit};
        item.begin_lba = start_lba[SmallW-1:0];
        item.end_lba   = end_lba[SmallW-1:0];
    end

endmodule

### rtl/core/pec_fifo.sv
module pec_fifo #(
    parameter int DEPTH = 4
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  pec_pkg::pec_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               empty,
    output pec_pkg::pec_item_t head_item
);
    import pec_pkg::*;

    localparam int PtrW = $clog2(DEPTH);
    localparam int CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

    pec_item_t       mem [DEPTH];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push, do_pop;

    assign full      = (cnt_reg == FullCnt);
    assign empty     = (cnt_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_item = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LastPtr) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LastPtr) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### rtl/core/pec_divpipe.sv
module pec_divpipe #(
    parameter int DV = 8,
    parameter int QW = 18
) (
    input  logic             aclk,
    input  logic             en,
    input  logic [DV+QW-1:0] dividend,
    input  logic [DV-1:0]    divisor,
    output logic [QW-1:0]    quot,
    output logic [DV-1:0]    remainder
);
    logic [DV-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [DV-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [DV:0]   trial;
        logic          ge;

        if (i == 0) begin : g_first
            assign rem_in = dividend[DV+QW-1:QW];
            assign low_in = dividend[QW-1:0];
        end else begin : g_rest
            assign rem_in = rem_reg[i-1];
            assign low_in = low_reg[i-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign ge    = trial >= {1'b0, divisor};

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= ge ? DV'(trial - {1'b0, divisor}) : trial[DV-1:0];
                low_reg[i] <= {low_in[QW-2:0], ge};
            end
        end
    end

    assign quot      = low_reg[QW-1];
    assign remainder = rem_reg[QW-1];

endmodule

### rtl/core/pec_back.sv
module pec_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          take,
    input  pec_pkg::pec_item_t            item,
    input  logic [pec_pkg::SptW-1:0]      spt,
    input  logic [pec_pkg::HpcW-1:0]      hpc,
    output logic                          res_valid,
    output logic [pec_pkg::OutDataW-1:0]  res_data
);
    import pec_pkg::*;

    localparam int Lat = Q1W + Q2W;

    logic            vld_reg [Lat];
    pec_side_t       side_reg [Lat];
    logic [SptW-1:0] br1_reg [Q2W];
    logic [SptW-1:0] er1_reg [Q2W];

    logic [Q1W-1:0]  bq1, eq1;
    logic [SptW-1:0] br1, er1;
    logic [Q2W-1:0]  bcyl, ecyl;
    logic [HpcW-1:0] bhead, ehead;
    logic [7:0]      bh_o, bsb_o, bcl_o, eh_o, esb_o, ecl_o;
    pec_side_t       side_in, side_out;

    assign side_in = '{empty: item.empty, flag: item.flag, ptype: item.ptype,
                       count: item.count, rel: item.rel,
                       begin_big: item.begin_big, end_big: item.end_big};

    pec_divpipe #(.DV(SptW), .QW(Q1W)) u_bdiv1 (
        .aclk(aclk), .en(en), .dividend(item.begin_lba), .divisor(spt),
        .quot(bq1), .remainder(br1)
    );
    pec_divpipe #(.DV(SptW), .QW(Q1W)) u_ediv1 (
        .aclk(aclk), .en(en), .dividend(item.end_lba), .divisor(spt),
        .quot(eq1), .remainder(er1)
    );
    pec_divpipe #(.DV(HpcW), .QW(Q2W)) u_bdiv2 (
        .aclk(aclk), .en(en), .dividend({1'b0, bq1}), .divisor(hpc),
        .quot(bcyl), .remainder(bhead)
    );
    pec_divpipe #(.DV(HpcW), .QW(Q2W)) u_ediv2 (
        .aclk(aclk), .en(en), .dividend({1'b0, eq1}), .divisor(hpc),
        .quot(ecyl), .remainder(ehead)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < Lat; i++) begin
                vld_reg[i] <= 1'b0;
            end
        end else if (en) begin
            vld_reg[0] <= take;
            for (int i = 1; i < Lat; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int i = 1; i < Lat; i++) begin
                side_reg[i] <= side_reg[i-1];
            end
            br1_reg[0] <= br1;
            er1_reg[0] <= er1;
            for (int i = 1; i < Q2W; i++) begin
                br1_reg[i] <= br1_reg[i-1];
                er1_reg[i] <= er1_reg[i-1];
            end
        end
    end

    assign side_out = side_reg[Lat-1];

    function automatic logic [23:0] chs_pack(input logic big, input logic [Q2W-1:0] cyl,
                                             input logic [HpcW-1:0] head,
                                             input logic [SptW-1:0] rem);
        logic [SptW:0] sec;
        logic          clamp;
        logic [9:0]    c;
        logic [7:0]    h;
        logic [5:0]    s;
        sec   = {1'b0, rem} + 1'b1;
        clamp = big || (head > HpcW'(CLAMP_HEAD)) || (sec > (SptW+1)'(CLAMP_SEC));
        c     = clamp ? CLAMP_CYL : cyl;
        h     = clamp ? CLAMP_HEAD : head[7:0];
        s     = clamp ? CLAMP_SEC : sec[5:0];
        return {c[7:0], c[9:8], s, h};
    endfunction

    assign {bcl_o, bsb_o, bh_o} = chs_pack(side_out.begin_big, bcyl, bhead, br1_reg[Q2W-1]);
    assign {ecl_o, esb_o, eh_o} = chs_pack(side_out.end_big, ecyl, ehead, er1_reg[Q2W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid <= 1'b0;
        end else if (en) begin
            res_valid <= vld_reg[Lat-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            if (side_out.empty) begin
                res_data <= '0;
            end else begin
                res_data <= {side_out.count, side_out.rel, ecl_o, esb_o, eh_o,
                             side_out.ptype, bcl_o, bsb_o, bh_o, side_out.flag};
            end
        end
    end

endmodule

### rtl/core/partition_entry_chs_encoder.sv
// Partition entry encoder: each s_ item (start LBA, sector count, type, boot flag,
// table base LBA) becomes one m_ item holding the 16-byte MBR entry, with begin and
// end CHS derived from registers 0 (sectors per track, reset 63) and 1 (heads per
// cylinder, reset 255); a zero register acts as one, out-of-range CHS clamps to
// 1023/254/63, and an item with zero count or zero type yields all zeros. One item
// is accepted per cycle while the queue is not full; results pass through two chained
// restoring divider pipelines (18 steps by sectors per track, then 10 steps by heads).
module partition_entry_chs_encoder #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // start_lba, sector_count, part_type, boot_flag, table_base_lba
    input  logic [pec_pkg::InDataW-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_flag, begin_head, begin_sector_byte, begin_cyl_low, out_type,
    // end_head, end_sector_byte, end_cyl_low, relative_start, out_count
    output logic [pec_pkg::OutDataW-1:0]  m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pec_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [pec_pkg::CfgDataW-1:0]  cfg_data
);
    import pec_pkg::*;

    logic [SptW-1:0] spt_reg;
    logic [HpcW-1:0] hpc_reg;
    logic [SptW-1:0] spt_eff;
    logic [HpcW-1:0] hpc_eff;
    pec_item_t       front_item, head_item;
    logic            q_full, q_empty, en, take;

    assign cfg_ready = 1'b1;
    assign spt_eff   = (spt_reg == '0) ? SptW'(1) : spt_reg;
    assign hpc_eff   = (hpc_reg == '0) ? HpcW'(1) : hpc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spt_reg <= SptW'(63);
            hpc_reg <= HpcW'(255);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SPT: spt_reg <= cfg_data[SptW-1:0];
                CFG_HPC: hpc_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    pec_front u_front (
        .in_data(s_tdata), .spt(spt_eff), .hpc(hpc_eff), .item(front_item)
    );

    assign s_tready = !q_full;

    pec_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .push(s_tvalid), .push_item(front_item), .full(q_full),
        .pop(take), .empty(q_empty), .head_item(head_item)
    );

    assign en   = !m_tvalid || m_tready;
    assign take = en && !q_empty;

    pec_back u_back (
        .aclk(aclk), .aresetn(aresetn), .en(en), .take(take), .item(head_item),
        .spt(spt_eff), .hpc(hpc_eff), .res_valid(m_tvalid), .res_data(m_tdata)
    );

endmodule
